FILE: sv/block_bitmap_allocator_top_macros.svh
// Assertion macros used by the bitmap allocator top module.
`ifndef BLOCK_BITMAP_ALLOCATOR_TOP_MACROS_SVH
`define BLOCK_BITMAP_ALLOCATOR_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define BBA_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bitmap allocator assertion failed");
`define BBA_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bitmap allocator assertion failed");
`else
`define BBA_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define BBA_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/bba_pkg.sv
// Types and constants of the bitmap block allocator.
package bba_pkg;

    localparam int WORD_BITS = 64;
    localparam int BIT_W     = 6;
    localparam int ID_W      = 10;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FREE,
        ST_ALLOC
    } t_state;

    typedef struct packed {
        logic            operation;
        logic [ID_W-1:0] block_id;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0] allocated_block;
        logic            disk_full;
    } t_resp;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] pos;
    } t_find_res;

endpackage

FILE: sv/bba_stream_if.sv
// Valid/ready channel that carries one word of payload type T.
interface bba_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/block_bitmap_allocator_top.sv
// First-fit bitmap block allocator with a 64-bit-per-word occupancy memory.
// A free is one read and one write back; a free of block 0 or of a block past NUM_BLOCKS-1 is dropped.
// An allocate scans one word per cycle and registers its result after k words are read,
// k being 1 to NUM_WORDS (16 by default); it waits to register it while an earlier result is unread.
// One item is in work at a time; a waiting result does not block the next acceptance.
// After reset a clearing pass zeroes every bitmap word; no item is taken during it.
`include "block_bitmap_allocator_top_macros.svh"

module block_bitmap_allocator_top #(
    parameter int unsigned NUM_BLOCKS         = 1024,
    parameter int unsigned FIRST_USABLE_BLOCK = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bba_stream_if.sink   i_req,
    bba_stream_if.source o_resp
);
    localparam int unsigned NUM_WORDS =
        (NUM_BLOCKS + bba_pkg::WORD_BITS - 1) / bba_pkg::WORD_BITS;
    localparam int IDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int W     = bba_pkg::WORD_BITS;

    bba_pkg::t_state    r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [bba_pkg::BIT_W-1:0] r_free_bit;
    logic [W-1:0]       r_rd_data;
    logic [W-1:0]       r_bitmap [NUM_WORDS];
    bba_pkg::t_resp     r_out, n_out;
    logic               r_out_valid;

    bba_pkg::t_find_res find_res;
    logic               in_ready, in_fire, free_ok, last, finish, can_out, ld_out;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [W-1:0]       wr_data;

    bba_find #(
        .NUM_BLOCKS         (NUM_BLOCKS),
        .FIRST_USABLE_BLOCK (FIRST_USABLE_BLOCK),
        .IDX_W              (IDX_W)
    ) u_find (
        .i_word (r_rd_data),
        .i_idx  (r_idx),
        .o_res  (find_res)
    );

    assign in_fire = i_req.valid && in_ready;
    assign free_ok = (i_req.data.block_id != '0)
                     && (32'(i_req.data.block_id) < NUM_BLOCKS);
    assign last    = (r_idx == IDX_W'(NUM_WORDS - 1));
    assign finish  = find_res.found || last;
    assign can_out = !r_out_valid || o_resp.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bba_pkg::ST_CLEAR: begin
                if (last) begin
                    n_state = bba_pkg::ST_IDLE;
                end
            end
            bba_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (i_req.data.operation == bba_pkg::OP_ALLOC) begin
                        n_state = bba_pkg::ST_ALLOC;
                    end else if (free_ok) begin
                        n_state = bba_pkg::ST_FREE;
                    end
                end
            end
            bba_pkg::ST_FREE: begin
                n_state = bba_pkg::ST_IDLE;
            end
            bba_pkg::ST_ALLOC: begin
                if (finish && can_out) begin
                    n_state = bba_pkg::ST_IDLE;
                end
            end
            default: n_state = bba_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        rd_addr  = r_idx;
        n_idx    = r_idx;
        wr_en    = 1'b0;
        wr_data  = r_rd_data;
        ld_out   = 1'b0;
        n_out    = r_out;
        unique case (r_state)
            bba_pkg::ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_data = '0;
                n_idx   = last ? '0 : r_idx + 1'b1;
            end
            bba_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                n_idx    = '0;
                if (i_req.data.operation == bba_pkg::OP_FREE) begin
                    rd_addr = IDX_W'(i_req.data.block_id >> bba_pkg::BIT_W);
                    n_idx   = IDX_W'(i_req.data.block_id >> bba_pkg::BIT_W);
                end else begin
                    rd_addr = '0;
                end
            end
            bba_pkg::ST_FREE: begin
                wr_en   = 1'b1;
                wr_data = r_rd_data & ~(W'(1) << r_free_bit);
            end
            bba_pkg::ST_ALLOC: begin
                if (finish && can_out) begin
                    ld_out = 1'b1;
                    if (find_res.found) begin
                        wr_en   = 1'b1;
                        wr_data = r_rd_data | (W'(1) << find_res.pos);
                        n_out.allocated_block = bba_pkg::ID_W'({r_idx, find_res.pos});
                        n_out.disk_full       = 1'b0;
                    end else begin
                        n_out.allocated_block = '0;
                        n_out.disk_full       = 1'b1;
                    end
                end else if (!finish) begin
                    rd_addr = r_idx + 1'b1;
                    n_idx   = r_idx + 1'b1;
                end
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bba_pkg::ST_CLEAR;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (ld_out) begin
                r_out_valid <= 1'b1;
            end else if (o_resp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_free_bit <= i_req.data.block_id[bba_pkg::BIT_W-1:0];
        end
        if (ld_out) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_bitmap[r_idx] <= wr_data;
        end
        r_rd_data <= r_bitmap[rd_addr];
    end

    assign i_req.ready  = in_ready;
    assign o_resp.valid = r_out_valid;
    assign o_resp.data  = r_out;

    `BBA_ASSERT_IMP(a_no_result_in_clear, i_clk, i_rst_n,
        r_state == bba_pkg::ST_CLEAR, !o_resp.valid)
    `BBA_ASSERT_IMP(a_full_gives_zero, i_clk, i_rst_n,
        o_resp.valid && o_resp.data.disk_full, o_resp.data.allocated_block == '0)
    `BBA_ASSERT_NXT(a_alloc_starts_scan, i_clk, i_rst_n,
        in_fire && (i_req.data.operation == bba_pkg::OP_ALLOC),
        (r_state == bba_pkg::ST_ALLOC) && (r_idx == '0))
    `BBA_ASSERT_IMP(a_scan_in_range, i_clk, i_rst_n,
        r_state == bba_pkg::ST_ALLOC, r_idx <= IDX_W'(NUM_WORDS - 1))
    `BBA_ASSERT_IMP(a_no_result_overwrite, i_clk, i_rst_n,
        ld_out, !r_out_valid || o_resp.ready)
endmodule

FILE: sv/bba_find.sv
// Lowest free usable bit of one bitmap word.
module bba_find #(
    parameter int unsigned NUM_BLOCKS         = 1024,
    parameter int unsigned FIRST_USABLE_BLOCK = 2,
    parameter int unsigned IDX_W              = 4
) (
    input  logic [bba_pkg::WORD_BITS-1:0] i_word,
    input  logic [IDX_W-1:0]              i_idx,
    output bba_pkg::t_find_res            o_res
);
    localparam int BLK_W = IDX_W + bba_pkg::BIT_W;
    localparam int CMP_W = BLK_W + 1;

    logic [bba_pkg::WORD_BITS-1:0] avail;

    always_comb begin
        logic [CMP_W-1:0] blk;
        blk = '0;
        for (int b = 0; b < bba_pkg::WORD_BITS; b++) begin
            blk      = {1'b0, i_idx, bba_pkg::BIT_W'(b)};
            avail[b] = !i_word[b] && (blk >= CMP_W'(FIRST_USABLE_BLOCK))
                       && (blk < CMP_W'(NUM_BLOCKS));
        end
    end

    always_comb begin
        o_res.found = |avail;
        o_res.pos   = '0;
        for (int b = bba_pkg::WORD_BITS - 1; b >= 0; b--) begin
            if (avail[b]) begin
                o_res.pos = bba_pkg::BIT_W'(b);
            end
        end
    end
endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of the first-fit bitmap block allocator: directed, fill and churn traffic.
module testbench;

    localparam int NUM_BLOCKS   = 1024;
    localparam int FIRST_USABLE = 2;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PRINT_LIMIT  = 40;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bba_stream_if #(.T(bba_pkg::t_req))  req_if ();
    bba_stream_if #(.T(bba_pkg::t_resp)) resp_if ();

    block_bitmap_allocator_top #(
        .NUM_BLOCKS         (NUM_BLOCKS),
        .FIRST_USABLE_BLOCK (FIRST_USABLE)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_resp  (resp_if)
    );

    logic [NUM_BLOCKS-1:0] block_used;
    bba_pkg::t_resp        expected_grants[$];
    bba_pkg::t_resp        grant_want;
    int                    mismatches;
    int                    grants_seen;
    int                    full_seen;
    int                    allocs_sent;
    int                    frees_sent;
    int                    quiet_cycles;
    bit                    steady;
    bit                    hold_armed;
    bit                    rx_hold;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        resp_if.ready <= !rx_hold && (steady || $urandom_range(99) >= 12);
    end

    // The receiver stops taking words for a long stretch once the fill test asks for it.
    initial begin
        wait (hold_armed);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && resp_if.valid && resp_if.ready) begin
            if (expected_grants.size() == 0) begin
                report_mismatch("unexpected word, block", resp_if.data.allocated_block, 0);
            end else begin
                grant_want = expected_grants.pop_front();
                grants_seen++;
                if (grant_want.disk_full) begin
                    full_seen++;
                end
                if (resp_if.data.allocated_block !== grant_want.allocated_block) begin
                    report_mismatch("allocated_block", resp_if.data.allocated_block,
                                    grant_want.allocated_block);
                end
                if (resp_if.data.disk_full !== grant_want.disk_full) begin
                    report_mismatch("disk_full", resp_if.data.disk_full, grant_want.disk_full);
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((req_if.valid && req_if.ready) || (resp_if.valid && resp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic apply_to_bitmap(input bba_pkg::t_req w);
        int             blk;
        bba_pkg::t_resp grant;
        if (w.operation == bba_pkg::OP_FREE) begin
            if (w.block_id != 0 && w.block_id < NUM_BLOCKS) begin
                block_used[w.block_id] = 1'b0;
            end
        end else begin
            grant.allocated_block = '0;
            grant.disk_full       = 1'b1;
            for (blk = FIRST_USABLE; blk < NUM_BLOCKS; blk++) begin
                if (!block_used[blk]) begin
                    block_used[blk]       = 1'b1;
                    grant.allocated_block = blk[bba_pkg::ID_W-1:0];
                    grant.disk_full       = 1'b0;
                    break;
                end
            end
            expected_grants.push_back(grant);
        end
    endtask

    task automatic send_word(input logic op, input logic [bba_pkg::ID_W-1:0] id);
        bba_pkg::t_req w;
        w.operation = op;
        w.block_id  = id;
        while (!steady && $urandom_range(99) < 12) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= w;
        @(posedge clk);
        while (!req_if.ready) begin
            @(posedge clk);
        end
        apply_to_bitmap(w);
        if (op == bba_pkg::OP_FREE) begin
            frees_sent++;
        end else begin
            allocs_sent++;
        end
    endtask

    function automatic logic [bba_pkg::ID_W-1:0] pick_used_block();
        int start;
        int k;
        int blk;
        start = $urandom_range(NUM_BLOCKS - 1, FIRST_USABLE);
        for (k = 0; k < NUM_BLOCKS; k++) begin
            blk = (start + k) % NUM_BLOCKS;
            if (blk >= FIRST_USABLE && block_used[blk]) begin
                return blk[bba_pkg::ID_W-1:0];
            end
        end
        return start[bba_pkg::ID_W-1:0];
    endfunction

    task automatic test_directed_cases();
        send_word(bba_pkg::OP_ALLOC, 10'd1023);
        send_word(bba_pkg::OP_ALLOC, 10'd0);
        send_word(bba_pkg::OP_ALLOC, 10'd341);
        send_word(bba_pkg::OP_FREE, 10'd3);
        send_word(bba_pkg::OP_ALLOC, 10'd0);
        send_word(bba_pkg::OP_FREE, 10'd0);
        send_word(bba_pkg::OP_ALLOC, 10'd0);
        send_word(bba_pkg::OP_FREE, 10'd1);
        send_word(bba_pkg::OP_ALLOC, 10'd0);
        send_word(bba_pkg::OP_FREE, 10'd4);
        send_word(bba_pkg::OP_FREE, 10'd4);
        send_word(bba_pkg::OP_FREE, 10'd1023);
        send_word(bba_pkg::OP_FREE, 10'd682);
        send_word(bba_pkg::OP_FREE, 10'd341);
        send_word(bba_pkg::OP_ALLOC, 10'd0);
        send_word(bba_pkg::OP_FREE, 10'd2);
        send_word(bba_pkg::OP_ALLOC, 10'd0);
        send_word(bba_pkg::OP_ALLOC, 10'd682);
    endtask

    // Fills every usable block, asks past full, then frees and reclaims word boundaries.
    task automatic test_fill_to_full();
        int n;
        n = 0;
        while (block_used[NUM_BLOCKS-1:FIRST_USABLE] != '1) begin
            if (n == 100) begin
                hold_armed = 1'b1;
            end
            steady = (n >= 400 && n < 700);
            send_word(bba_pkg::OP_ALLOC, bba_pkg::ID_W'($urandom_range(NUM_BLOCKS - 1)));
            n++;
        end
        steady = 1'b0;
        repeat (3) send_word(bba_pkg::OP_ALLOC, bba_pkg::ID_W'($urandom_range(NUM_BLOCKS - 1)));
        send_word(bba_pkg::OP_FREE, 10'd1023);
        send_word(bba_pkg::OP_ALLOC, 10'd0);
        send_word(bba_pkg::OP_FREE, 10'd64);
        send_word(bba_pkg::OP_FREE, 10'd63);
        repeat (3) send_word(bba_pkg::OP_ALLOC, 10'd0);
    endtask

    task automatic test_churn();
        int pick;
        repeat (150) send_word(bba_pkg::OP_FREE, pick_used_block());
        repeat (550) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                send_word(bba_pkg::OP_ALLOC, bba_pkg::ID_W'($urandom_range(NUM_BLOCKS - 1)));
            end else if (pick < 88) begin
                send_word(bba_pkg::OP_FREE, pick_used_block());
            end else if ($urandom_range(3) == 0) begin
                send_word(bba_pkg::OP_FREE, bba_pkg::ID_W'($urandom_range(1)));
            end else begin
                send_word(bba_pkg::OP_FREE, bba_pkg::ID_W'($urandom_range(NUM_BLOCKS - 1)));
            end
        end
    endtask

    initial begin
        req_if.valid  = 1'b0;
        req_if.data   = '0;
        block_used    = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_fill_to_full();
        test_churn();

        req_if.valid <= 1'b0;
        while (expected_grants.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d allocate and %0d free words, including a fill to full.",
                 allocs_sent, frees_sent);
        $display("Checked %0d grants, %0d of them reporting a full disk.", grants_seen, full_seen);
        if (mismatches == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
